// File: rtl/set_assoc_lru_cache_sim_unit_defines.svh
// Assertion macros shared by the cache simulator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SET_ASSOC_LRU_CACHE_SIM_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SALC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("salc check failed");

// next-cycle implication, disabled while reset is asserted
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("salc check failed");

`endif

// File: rtl/salc_pkg.sv
// Package for the set-associative LRU cache simulator.
// Holds default sizes, command codes and register indexes; no dependencies.
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 10;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 32;

  localparam int CNT_W   = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_MODIFY = 2'd1,
    CMD_IFETCH = 2'd2
  } cmd_t;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;

  localparam logic [3:0] SET_BITS_RST = 4'd4;
  localparam logic [4:0] OFF_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST     = 4'd1;

endpackage

// File: rtl/salc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/set_assoc_lru_cache_sim_unit.sv
// Channel    Handshake                        Payload
// input      start & !busy                    in_cmd, in_address
// result     out_valid (one cycle, no stall)  out_access_*, out_last_of_item, out_*_total
// config     psel & penable & pwrite          paddr, pwdata, prdata (pready tied high)
//
// Load/store is one access and modify two; a fetch is ignored and gives no result. Each
// access is one set read from the line RAM and one write-back of the updated set.
// After reset a clearing pass over all 2**MAX_SET_BITS sets (1024 by default) holds busy high.
// A result is shown on the cycle after its write-back; the next item can be taken with the item's last result.
// The receiver cannot stall; results are never held.
// Depends on salc_pkg, salc_ram and set_assoc_lru_cache_sim_unit_defines.svh.
`include "set_assoc_lru_cache_sim_unit_defines.svh"
module set_assoc_lru_cache_sim_unit
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_cmd,
  input  logic [ADDR_WIDTH-1:0] in_address,
  output logic                  out_valid,
  output logic                  out_access_hit,
  output logic                  out_access_miss,
  output logic                  out_access_eviction,
  output logic                  out_last_of_item,
  output logic [CNT_W-1:0]      out_hits_total,
  output logic [CNT_W-1:0]      out_misses_total,
  output logic [CNT_W-1:0]      out_evictions_total,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int SET_W  = MAX_SET_BITS;
  localparam int NSETS  = 1 << MAX_SET_BITS;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [RANK_W-1:0]     rank;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_REREAD} state_t;

  state_t                state_r, state_nxt;
  logic [SET_W-1:0]      clr_r, clr_nxt;
  logic [SET_W-1:0]      set_r, set_nxt;
  logic [ADDR_WIDTH-1:0] tag_r, tag_nxt;
  logic                  two_r, two_nxt;
  logic                  ov_r, ov_nxt;
  logic                  hit_r, hit_nxt;
  logic                  miss_r, miss_nxt;
  logic                  evict_r, evict_nxt;
  logic                  last_r, last_nxt;
  logic [CNT_W-1:0]      hcnt_r, hcnt_nxt;
  logic [CNT_W-1:0]      mcnt_r, mcnt_nxt;
  logic [CNT_W-1:0]      ecnt_r, ecnt_nxt;

  logic [3:0] cfg_s_r;
  logic [4:0] cfg_b_r;
  logic [3:0] cfg_w_r;

  logic [4:0]            s_eff, b_eff;
  logic [5:0]            sh_tag;
  logic [5:0]            ways6;
  logic [RANK_W-1:0]     ways_m1;
  logic [ADDR_WIDTH-1:0] set_mask;
  logic [SET_W-1:0]      set_in;
  logic [ADDR_WIDTH-1:0] tag_in;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [SET_W-1:0] ram_raddr;
  row_t             ram_wdata;
  row_t             rd_row;
  row_t             new_row;

  logic              lk_hit, lk_inv, lk_evict;
  logic [RANK_W-1:0] hit_way, inv_way, lru_way, tgt_way;
  logic [RANK_W-1:0] tgt_rank;
  logic              cfg_wr;

  // configuration registers
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_s_r <= SET_BITS_RST;
      cfg_b_r <= OFF_BITS_RST;
      cfg_w_r <= WAYS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SET_BITS: cfg_s_r <= pwdata[3:0];
        REG_OFF_BITS: cfg_b_r <= pwdata[4:0];
        REG_WAYS:     cfg_w_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS: prdata = PDATA_W'(cfg_s_r);
      REG_OFF_BITS: prdata = PDATA_W'(cfg_b_r);
      REG_WAYS:     prdata = PDATA_W'(cfg_w_r);
      default:      prdata = '0;
    endcase
  end

  // saturate registers to their legal ranges
  always_comb begin
    if (cfg_s_r == 4'd0) begin
      s_eff = 5'd1;
    end else if (5'(cfg_s_r) > 5'(MAX_SET_BITS)) begin
      s_eff = 5'(MAX_SET_BITS);
    end else begin
      s_eff = 5'(cfg_s_r);
    end
    if (cfg_b_r == 5'd0) begin
      b_eff = 5'd1;
    end else if (cfg_b_r > 5'd16) begin
      b_eff = 5'd16;
    end else begin
      b_eff = cfg_b_r;
    end
    if (cfg_w_r == 4'd0) begin
      ways6 = 6'd1;
    end else if (6'(cfg_w_r) > 6'(MAX_WAYS)) begin
      ways6 = 6'(MAX_WAYS);
    end else begin
      ways6 = 6'(cfg_w_r);
    end
  end

  assign ways_m1  = RANK_W'(ways6 - 6'd1);
  assign sh_tag   = 6'(s_eff) + 6'(b_eff);
  assign set_mask = (ADDR_WIDTH'(1) << s_eff) - ADDR_WIDTH'(1);
  assign set_in   = SET_W'((in_address >> b_eff) & set_mask);
  assign tag_in   = in_address >> sh_tag;

  // set lookup and LRU update on the row read back from the RAM
  always_comb begin
    logic [MAX_WAYS-1:0] in_use;
    logic                found_h, found_i;
    lk_hit   = 1'b0;
    lk_inv   = 1'b0;
    hit_way  = '0;
    inv_way  = '0;
    lru_way  = '0;
    found_h  = 1'b0;
    found_i  = 1'b0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = 6'(i) < ways6;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && rd_row[i].valid && rd_row[i].tag == tag_r && !found_h) begin
        found_h = 1'b1;
        hit_way = RANK_W'(i);
      end
      if (in_use[i] && !rd_row[i].valid && !found_i) begin
        found_i = 1'b1;
        inv_way = RANK_W'(i);
      end
    end
    lk_hit = found_h;
    lk_inv = found_i;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && rd_row[i].rank < rd_row[lru_way].rank) begin
        lru_way = RANK_W'(i);
      end
    end
    lk_evict = !lk_hit && !lk_inv;
    tgt_way  = lk_hit ? hit_way : (lk_inv ? inv_way : lru_way);
    tgt_rank = rd_row[tgt_way].rank;
    new_row  = rd_row;
    new_row[tgt_way].valid = 1'b1;
    new_row[tgt_way].tag   = tag_r;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (in_use[j] && new_row[j].valid && rd_row[j].rank > tgt_rank) begin
        new_row[j].rank = rd_row[j].rank - RANK_W'(1);
      end
    end
    new_row[tgt_way].rank = ways_m1;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    set_nxt   = set_r;
    tag_nxt   = tag_r;
    two_nxt   = two_r;
    ov_nxt    = 1'b0;
    hit_nxt   = hit_r;
    miss_nxt  = miss_r;
    evict_nxt = evict_r;
    last_nxt  = last_r;
    hcnt_nxt  = hcnt_r;
    mcnt_nxt  = mcnt_r;
    ecnt_nxt  = ecnt_r;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = new_row;
    ram_raddr = (state_r == ST_REREAD) ? set_r : set_in;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + SET_W'(1);
        if (clr_r == SET_W'(NSETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && (in_cmd == CMD_ACCESS || in_cmd == CMD_MODIFY)) begin
          set_nxt   = set_in;
          tag_nxt   = tag_in;
          two_nxt   = (in_cmd == CMD_MODIFY);
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ram_we    = 1'b1;
        ov_nxt    = 1'b1;
        hit_nxt   = lk_hit;
        miss_nxt  = !lk_hit;
        evict_nxt = lk_evict;
        last_nxt  = !two_r;
        if (lk_hit) begin
          hcnt_nxt = (hcnt_r == '1) ? hcnt_r : hcnt_r + CNT_W'(1);
        end else begin
          mcnt_nxt = (mcnt_r == '1) ? mcnt_r : mcnt_r + CNT_W'(1);
        end
        if (lk_evict) begin
          ecnt_nxt = (ecnt_r == '1) ? ecnt_r : ecnt_r + CNT_W'(1);
        end
        two_nxt   = 1'b0;
        state_nxt = two_r ? ST_REREAD : ST_IDLE;
      end
      ST_REREAD: begin
        state_nxt = ST_LOOK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      two_r   <= 1'b0;
      ov_r    <= 1'b0;
      hcnt_r  <= '0;
      mcnt_r  <= '0;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      two_r   <= two_nxt;
      ov_r    <= ov_nxt;
      hcnt_r  <= hcnt_nxt;
      mcnt_r  <= mcnt_nxt;
      ecnt_r  <= ecnt_nxt;
    end
    set_r   <= set_nxt;
    tag_r   <= tag_nxt;
    hit_r   <= hit_nxt;
    miss_r  <= miss_nxt;
    evict_r <= evict_nxt;
    last_r  <= last_nxt;
  end

  salc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NSETS)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_row)
  );

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = ov_r;
  assign out_access_hit      = hit_r;
  assign out_access_miss     = miss_r;
  assign out_access_eviction = evict_r;
  assign out_last_of_item    = last_r;
  assign out_hits_total      = hcnt_r;
  assign out_misses_total    = mcnt_r;
  assign out_evictions_total = ecnt_r;

  `SALC_ASSERT_NEXT(a_look_gives_result, clk, rst_n, state_r == ST_LOOK, ov_r)
  `SALC_ASSERT_IMPL(a_hit_xor_miss, clk, rst_n, ov_r, (hit_r != miss_r))
  `SALC_ASSERT_IMPL(a_evict_on_miss, clk, rst_n, ov_r && evict_r, miss_r)
  `SALC_ASSERT_IMPL(a_modify_pair, clk, rst_n, ov_r && !last_r, ##2 (ov_r && last_r))
  `SALC_ASSERT_IMPL(a_write_when_busy, clk, rst_n, ram_we, busy)

endmodule
